// ===== rtl/tpgac_pkg.sv =====
`default_nettype none

package tpgac_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;

    // CORDIC datapath: vectoring inputs are normalized to 2^40, plus growth
    localparam int CORDIC_W = 46;
    localparam logic signed [CORDIC_W-1:0] NORM_LIM = CORDIC_W'(64'sd1 <<< 40);
    localparam logic signed [CORDIC_W-1:0] CORDIC_K_Q30 = CORDIC_W'(64'sd652032874);

    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_GOAL = 2'd1;
    localparam logic [1:0] PH_EXT  = 2'd2;

    localparam logic [2:0] REG_GOAL_X     = 3'd0;
    localparam logic [2:0] REG_GOAL_Y     = 3'd1;
    localparam logic [2:0] REG_TOLERANCE  = 3'd2;
    localparam logic [2:0] REG_CRUISE     = 3'd3;
    localparam logic [2:0] REG_TURN_GAIN  = 3'd4;
    localparam logic [2:0] REG_EXTEND     = 3'd5;

    typedef struct packed {
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic [15:0]        arrive_tolerance;
        logic [14:0]        cruise_speed;
        logic [15:0]        turn_gain;
        logic [20:0]        extend_distance;
    } cfg_t;

    typedef enum logic { COR_VEC, COR_ROT } cor_mode_t;

    typedef struct packed {
        logic      start;
        cor_mode_t mode;
    } cor_req_t;

    typedef enum logic [2:0] {
        CS_IDLE, CS_NORM, CS_PRE, CS_ITER, CS_FIN
    } cor_state_t;

    typedef enum logic [3:0] {
        MOP_AXX, MOP_AYY, MOP_QYY, MOP_QZZ, MOP_QXX, MOP_QWW, MOP_QXZ,
        MOP_QWY, MOP_QXY, MOP_QWZ, MOP_GAIN, MOP_EXTC, MOP_EXTS
    } mop_t;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_MUL, SQ_ACC, SQ_NEXT, SQ_SQRT, SQ_DECIDE, SQ_YAW, SQ_YAWW,
        SQ_BRANCH, SQ_HEADW, SQ_WRAP, SQ_ROTW, SQ_OUT
    } seq_state_t;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd210828714;
            5'd1:  v = 32'sd124459457;
            5'd2:  v = 32'sd65760959;
            5'd3:  v = 32'sd33381290;
            5'd4:  v = 32'sd16755422;
            5'd5:  v = 32'sd8385879;
            5'd6:  v = 32'sd4193963;
            5'd7:  v = 32'sd2097109;
            5'd8:  v = 32'sd1048571;
            5'd9:  v = 32'sd524287;
            5'd10: v = 32'sd262144;
            5'd11: v = 32'sd131072;
            5'd12: v = 32'sd65536;
            5'd13: v = 32'sd32768;
            5'd14: v = 32'sd16384;
            5'd15: v = 32'sd8192;
            5'd16: v = 32'sd4096;
            5'd17: v = 32'sd2048;
            5'd18: v = 32'sd1024;
            5'd19: v = 32'sd512;
            5'd20: v = 32'sd256;
            5'd21: v = 32'sd128;
            5'd22: v = 32'sd64;
            5'd23: v = 32'sd32;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tpgac_regs.sv =====
`default_nettype none

module tpgac_regs (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output tpgac_pkg::cfg_t        cfg
);

    tpgac_pkg::cfg_t cfg_reg;
    logic [2:0]      idx;
    logic            wr_en;

    assign idx   = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal_x           <= '0;
            cfg_reg.goal_y           <= '0;
            cfg_reg.arrive_tolerance <= 16'd3277;
            cfg_reg.cruise_speed     <= 15'd410;
            cfg_reg.turn_gain        <= 16'd6144;
            cfg_reg.extend_distance  <= 21'd19661;
        end else if (wr_en) begin
            case (idx)
                tpgac_pkg::REG_GOAL_X:    cfg_reg.goal_x           <= $signed(pwdata);
                tpgac_pkg::REG_GOAL_Y:    cfg_reg.goal_y           <= $signed(pwdata);
                tpgac_pkg::REG_TOLERANCE: cfg_reg.arrive_tolerance <= pwdata[15:0];
                tpgac_pkg::REG_CRUISE:    cfg_reg.cruise_speed     <= pwdata[14:0];
                tpgac_pkg::REG_TURN_GAIN: cfg_reg.turn_gain        <= pwdata[15:0];
                tpgac_pkg::REG_EXTEND:    cfg_reg.extend_distance  <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            tpgac_pkg::REG_GOAL_X:    prdata = cfg_reg.goal_x;
            tpgac_pkg::REG_GOAL_Y:    prdata = cfg_reg.goal_y;
            tpgac_pkg::REG_TOLERANCE: prdata = 32'(cfg_reg.arrive_tolerance);
            tpgac_pkg::REG_CRUISE:    prdata = 32'(cfg_reg.cruise_speed);
            tpgac_pkg::REG_TURN_GAIN: prdata = 32'(cfg_reg.turn_gain);
            tpgac_pkg::REG_EXTEND:    prdata = 32'(cfg_reg.extend_distance);
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tpgac_isqrt.sv =====
`default_nettype none

module tpgac_isqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] v_in,
    output logic             done,
    output logic [31:0]      root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    assign done  = done_reg;
    assign root  = r_reg[31:0];
    assign trial = r_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            v_next    = v_in;
            r_next    = '0;
            bit_next  = 64'd1 << 62;
        end else if (busy_reg) begin
            // one result bit per step, two radicand bits
            if (v_reg >= trial) begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 64'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

endmodule

`default_nettype wire

// ===== rtl/tpgac_cordic.sv =====
`default_nettype none

module tpgac_cordic #(
    parameter int CORDIC_ITERATIONS = tpgac_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire tpgac_pkg::cor_req_t                 req,
    input  wire logic signed [tpgac_pkg::CORDIC_W-1:0] x_in,
    input  wire logic signed [tpgac_pkg::CORDIC_W-1:0] y_in,
    input  wire logic signed [31:0]                  z_in,
    output logic                                     done,
    output logic signed [tpgac_pkg::CORDIC_W-1:0]    x_out,
    output logic signed [tpgac_pkg::CORDIC_W-1:0]    y_out,
    output logic signed [31:0]                       z_out
);

    localparam int CNTW = $clog2(CORDIC_ITERATIONS);

    tpgac_pkg::cor_state_t st_reg, st_next;
    tpgac_pkg::cor_mode_t  mode_reg, mode_next;
    logic                  neg_reg, neg_next;
    logic                  done_reg, done_next;
    logic [CNTW-1:0]       cnt_reg, cnt_next;
    logic signed [tpgac_pkg::CORDIC_W-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [31:0]    z_reg, z_next, at;
    logic                  small_xy, rot_pos;

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = tpgac_pkg::atan_q28(5'(cnt_reg));
    assign small_xy = (x_reg < tpgac_pkg::NORM_LIM) && (x_reg > -tpgac_pkg::NORM_LIM) &&
                      (y_reg < tpgac_pkg::NORM_LIM) && (y_reg > -tpgac_pkg::NORM_LIM);
    // rotate toward positive angle: vectoring drives y to zero, rotation drives z
    assign rot_pos = (mode_reg == tpgac_pkg::COR_VEC) ? !(y_reg > 0) : (z_reg >= 0);

    always_comb begin
        st_next   = st_reg;
        mode_next = mode_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        case (st_reg)
            tpgac_pkg::CS_IDLE: begin
                if (req.start) begin
                    mode_next = req.mode;
                    neg_next  = 1'b0;
                    if (req.mode == tpgac_pkg::COR_VEC) begin
                        x_next = x_in;
                        y_next = y_in;
                        z_next = '0;
                        if (x_in == 0 && y_in == 0) begin
                            done_next = 1'b1;
                        end else begin
                            st_next = tpgac_pkg::CS_NORM;
                        end
                    end else begin
                        x_next  = tpgac_pkg::CORDIC_K_Q30;
                        y_next  = '0;
                        z_next  = z_in;
                        st_next = tpgac_pkg::CS_PRE;
                    end
                end
            end
            tpgac_pkg::CS_NORM: begin
                if (small_xy) begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end else begin
                    st_next = tpgac_pkg::CS_PRE;
                end
            end
            tpgac_pkg::CS_PRE: begin
                cnt_next = '0;
                st_next  = tpgac_pkg::CS_ITER;
                if (mode_reg == tpgac_pkg::COR_VEC) begin
                    if (x_reg < 0) begin
                        if (y_reg >= 0) begin
                            x_next = y_reg;
                            y_next = -x_reg;
                            z_next = tpgac_pkg::HALF_PI_Q28;
                        end else begin
                            x_next = -y_reg;
                            y_next = x_reg;
                            z_next = -tpgac_pkg::HALF_PI_Q28;
                        end
                    end
                end else if (z_reg > tpgac_pkg::HALF_PI_Q28) begin
                    z_next   = z_reg - tpgac_pkg::PI_Q28;
                    neg_next = 1'b1;
                end else if (z_reg < -tpgac_pkg::HALF_PI_Q28) begin
                    z_next   = z_reg + tpgac_pkg::PI_Q28;
                    neg_next = 1'b1;
                end
            end
            tpgac_pkg::CS_ITER: begin
                if (rot_pos) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
                if (cnt_reg == CNTW'(CORDIC_ITERATIONS - 1)) begin
                    st_next = tpgac_pkg::CS_FIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tpgac_pkg::CS_FIN: begin
                // undo the half-turn taken out before rotating
                if (neg_reg) begin
                    x_next = -x_reg;
                    y_next = -y_reg;
                end
                done_next = 1'b1;
                st_next   = tpgac_pkg::CS_IDLE;
            end
            default: st_next = tpgac_pkg::CS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= tpgac_pkg::CS_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

endmodule

`default_nettype wire

// ===== rtl/two_phase_goal_approach_controller.sv =====
`default_nettype none
// Start items and idle ticks pass straight to the output state; phase-two ticks compute the
// distance (no square root when a delta saturates the distance); phase-one ticks take a time set
// by the 32-step square root, the normalizing shifts plus CORDIC_ITERATIONS steps of the shared
// CORDIC unit, and the shared multiplier.
// One item at a time; s_tready is high only between items, a result waits in the output reg.
// Reset (aresetn low, synchronous): phase idle, target at zero, registers at their defaults.

module two_phase_goal_approach_controller #(
    parameter int CORDIC_ITERATIONS = tpgac_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
    input  wire logic [127:0] s_tdata,
    // kind
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // linear_cmd, angular_cmd, attach_pulse, phase_now, distance, zero fill
    output logic [71:0]       m_tdata,
    // cmd_valid
    output logic              m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW = tpgac_pkg::CORDIC_W;

    tpgac_pkg::cfg_t       cfg;
    tpgac_pkg::seq_state_t st_reg, st_next;
    tpgac_pkg::mop_t       mop_reg, mop_next;
    tpgac_pkg::cor_req_t   cor_req;

    logic [1:0]         phase_reg, phase_next;
    logic signed [31:0] tx_reg, tx_next, ty_reg, ty_next;
    logic signed [32:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [15:0] qx_reg, qx_next, qy_reg, qy_next, qz_reg, qz_next, qw_reg, qw_next;
    logic signed [65:0] prod_reg, prod_next, acc_reg, acc_next;
    logic [30:0]        dist_reg, dist_next;
    logic signed [31:0] n_reg, n_next, s_reg, s_next, g_reg, g_next, yaw_reg, yaw_next;
    logic signed [32:0] err_reg, err_next, c_reg, c_next, sn_reg, sn_next;
    logic               rv_reg, rv_next, ratt_reg, ratt_next;
    logic [15:0]        rlin_reg, rlin_next, rang_reg, rang_next;
    logic               mv_reg, mv_next, muser_reg, muser_next;
    logic [71:0]        mdata_reg, mdata_next;

    logic signed [32:0] dx_in, dy_in, ax, ay, opa, opb;
    logic               sat_d, clr, sub, far, yaw_zero;
    logic signed [65:0] rnd28, rnd30;
    logic signed [33:0] tsum, g2, ag2;
    logic signed [CW-1:0] cor_x_in, cor_y_in, cor_x, cor_y;
    logic signed [31:0] cor_z_in, cor_z;
    logic               cor_done, sqrt_start, sqrt_done;
    logic [31:0]        sqrt_root;

    assign pready   = 1'b1;
    assign s_tready = (st_reg == tpgac_pkg::SQ_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    tpgac_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tpgac_cordic #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cor_req),
        .x_in    (cor_x_in),
        .y_in    (cor_y_in),
        .z_in    (cor_z_in),
        .done    (cor_done),
        .x_out   (cor_x),
        .y_out   (cor_y),
        .z_out   (cor_z)
    );

    tpgac_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .v_in    (acc_reg[63:0]),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign dx_in = 33'(tx_reg) - 33'($signed(s_tdata[31:0]));
    assign dy_in = 33'(ty_reg) - 33'($signed(s_tdata[63:32]));
    assign ax    = dx_reg[32] ? -dx_reg : dx_reg;
    assign ay    = dy_reg[32] ? -dy_reg : dy_reg;
    assign sat_d = (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
    assign far   = dist_reg > 31'(cfg.arrive_tolerance);

    assign rnd28 = (acc_reg + (66'sd1 <<< 27)) >>> 28;
    assign rnd30 = (acc_reg + (66'sd1 <<< 29)) >>> 30;
    assign tsum  = 34'(tx_reg) + $signed(rnd30[33:0]);

    assign g2       = 34'(g_reg) <<< 1;
    assign ag2      = g2[33] ? -g2 : g2;
    assign yaw_zero = (n_reg == 0) || (ag2 >= 34'(n_reg));

    // shared multiplier operands and accumulate mode per micro-op
    always_comb begin
        opa = '0;
        opb = '0;
        clr = 1'b0;
        sub = 1'b0;
        case (mop_reg)
            tpgac_pkg::MOP_AXX:  begin opa = ax; opb = ax; clr = 1'b1; end
            tpgac_pkg::MOP_AYY:  begin opa = ay; opb = ay; end
            tpgac_pkg::MOP_QYY:  begin opa = 33'(qy_reg); opb = 33'(qy_reg); clr = 1'b1; end
            tpgac_pkg::MOP_QZZ:  begin opa = 33'(qz_reg); opb = 33'(qz_reg); end
            tpgac_pkg::MOP_QXX:  begin opa = 33'(qx_reg); opb = 33'(qx_reg); end
            tpgac_pkg::MOP_QWW:  begin opa = 33'(qw_reg); opb = 33'(qw_reg); end
            tpgac_pkg::MOP_QXZ:  begin opa = 33'(qx_reg); opb = 33'(qz_reg); clr = 1'b1; end
            tpgac_pkg::MOP_QWY:  begin opa = 33'(qw_reg); opb = 33'(qy_reg); sub = 1'b1; end
            tpgac_pkg::MOP_QXY:  begin opa = 33'(qx_reg); opb = 33'(qy_reg); clr = 1'b1; end
            tpgac_pkg::MOP_QWZ:  begin opa = 33'(qw_reg); opb = 33'(qz_reg); end
            tpgac_pkg::MOP_GAIN: begin
                opa = $signed({17'd0, cfg.turn_gain}); opb = err_reg; clr = 1'b1;
            end
            tpgac_pkg::MOP_EXTC: begin
                opa = $signed({12'd0, cfg.extend_distance}); opb = c_reg; clr = 1'b1;
            end
            tpgac_pkg::MOP_EXTS: begin
                opa = $signed({12'd0, cfg.extend_distance}); opb = sn_reg; clr = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        st_next    = st_reg;
        mop_next   = mop_reg;
        phase_next = phase_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        qz_next    = qz_reg;
        qw_next    = qw_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        dist_next  = dist_reg;
        n_next     = n_reg;
        s_next     = s_reg;
        g_next     = g_reg;
        yaw_next   = yaw_reg;
        err_next   = err_reg;
        c_next     = c_reg;
        sn_next    = sn_reg;
        rv_next    = rv_reg;
        ratt_next  = ratt_reg;
        rlin_next  = rlin_reg;
        rang_next  = rang_reg;
        mv_next    = mv_reg && !m_tready;
        muser_next = muser_reg;
        mdata_next = mdata_reg;
        cor_req.start = 1'b0;
        cor_req.mode  = tpgac_pkg::COR_VEC;
        cor_x_in   = '0;
        cor_y_in   = '0;
        cor_z_in   = '0;
        sqrt_start = 1'b0;

        case (st_reg)
            tpgac_pkg::SQ_IDLE: begin
                if (s_tvalid) begin
                    rv_next   = 1'b0;
                    ratt_next = 1'b0;
                    rlin_next = '0;
                    rang_next = '0;
                    dist_next = '0;
                    if (!s_tuser) begin
                        tx_next    = cfg.goal_x;
                        ty_next    = cfg.goal_y;
                        phase_next = tpgac_pkg::PH_GOAL;
                        st_next    = tpgac_pkg::SQ_OUT;
                    end else if (phase_reg == tpgac_pkg::PH_GOAL ||
                                 phase_reg == tpgac_pkg::PH_EXT) begin
                        dx_next  = dx_in;
                        dy_next  = dy_in;
                        qx_next  = $signed(s_tdata[79:64]);
                        qy_next  = $signed(s_tdata[95:80]);
                        qz_next  = $signed(s_tdata[111:96]);
                        qw_next  = $signed(s_tdata[127:112]);
                        mop_next = tpgac_pkg::MOP_AXX;
                        st_next  = tpgac_pkg::SQ_MUL;
                    end else begin
                        phase_next = tpgac_pkg::PH_IDLE;
                        st_next    = tpgac_pkg::SQ_OUT;
                    end
                end
            end
            tpgac_pkg::SQ_MUL: begin
                if (mop_reg == tpgac_pkg::MOP_AXX && sat_d) begin
                    dist_next = 31'h7FFF_FFFF;
                    st_next   = tpgac_pkg::SQ_DECIDE;
                end else begin
                    prod_next = opa * opb;
                    st_next   = tpgac_pkg::SQ_ACC;
                end
            end
            tpgac_pkg::SQ_ACC: begin
                if (clr) begin
                    acc_next = sub ? -prod_reg : prod_reg;
                end else begin
                    acc_next = sub ? acc_reg - prod_reg : acc_reg + prod_reg;
                end
                st_next = tpgac_pkg::SQ_NEXT;
            end
            tpgac_pkg::SQ_NEXT: begin
                st_next = tpgac_pkg::SQ_MUL;
                case (mop_reg)
                    tpgac_pkg::MOP_AXX: mop_next = tpgac_pkg::MOP_AYY;
                    tpgac_pkg::MOP_AYY: begin
                        sqrt_start = 1'b1;
                        st_next    = tpgac_pkg::SQ_SQRT;
                    end
                    tpgac_pkg::MOP_QYY: mop_next = tpgac_pkg::MOP_QZZ;
                    tpgac_pkg::MOP_QZZ: begin
                        s_next   = $signed(acc_reg[31:0]);
                        mop_next = tpgac_pkg::MOP_QXX;
                    end
                    tpgac_pkg::MOP_QXX: mop_next = tpgac_pkg::MOP_QWW;
                    tpgac_pkg::MOP_QWW: begin
                        n_next   = $signed(acc_reg[31:0]);
                        mop_next = tpgac_pkg::MOP_QXZ;
                    end
                    tpgac_pkg::MOP_QXZ: mop_next = tpgac_pkg::MOP_QWY;
                    tpgac_pkg::MOP_QWY: begin
                        g_next   = $signed(acc_reg[31:0]);
                        mop_next = tpgac_pkg::MOP_QXY;
                    end
                    tpgac_pkg::MOP_QXY: mop_next = tpgac_pkg::MOP_QWZ;
                    tpgac_pkg::MOP_QWZ: st_next = tpgac_pkg::SQ_YAW;
                    tpgac_pkg::MOP_GAIN: begin
                        rlin_next = 16'(cfg.cruise_speed);
                        if (rnd28 > 66'sd32767) begin
                            rang_next = 16'h7FFF;
                        end else if (rnd28 < -66'sd32768) begin
                            rang_next = 16'h8000;
                        end else begin
                            rang_next = rnd28[15:0];
                        end
                        st_next = tpgac_pkg::SQ_OUT;
                    end
                    tpgac_pkg::MOP_EXTC: begin
                        if (tsum > 34'sd2147483647) begin
                            tx_next = 32'sh7FFF_FFFF;
                        end else if (tsum < -34'sd2147483648) begin
                            tx_next = 32'sh8000_0000;
                        end else begin
                            tx_next = tsum[31:0];
                        end
                        mop_next = tpgac_pkg::MOP_EXTS;
                    end
                    tpgac_pkg::MOP_EXTS: begin
                        // ty follows the same saturating add
                        if (34'(ty_reg) + $signed(rnd30[33:0]) > 34'sd2147483647) begin
                            ty_next = 32'sh7FFF_FFFF;
                        end else if (34'(ty_reg) + $signed(rnd30[33:0]) < -34'sd2147483648) begin
                            ty_next = 32'sh8000_0000;
                        end else begin
                            ty_next = ty_reg + $signed(rnd30[31:0]);
                        end
                        phase_next = tpgac_pkg::PH_EXT;
                        st_next    = tpgac_pkg::SQ_OUT;
                    end
                    default: st_next = tpgac_pkg::SQ_OUT;
                endcase
            end
            tpgac_pkg::SQ_SQRT: begin
                if (sqrt_done) begin
                    dist_next = sqrt_root[31] ? 31'h7FFF_FFFF : sqrt_root[30:0];
                    st_next   = tpgac_pkg::SQ_DECIDE;
                end
            end
            tpgac_pkg::SQ_DECIDE: begin
                rv_next = 1'b1;
                if (phase_reg == tpgac_pkg::PH_EXT) begin
                    if (far) begin
                        rlin_next = 16'(cfg.cruise_speed);
                    end else begin
                        ratt_next  = 1'b1;
                        phase_next = tpgac_pkg::PH_IDLE;
                    end
                    st_next = tpgac_pkg::SQ_OUT;
                end else begin
                    mop_next = tpgac_pkg::MOP_QYY;
                    st_next  = tpgac_pkg::SQ_MUL;
                end
            end
            tpgac_pkg::SQ_YAW: begin
                if (yaw_zero) begin
                    yaw_next = '0;
                    st_next  = tpgac_pkg::SQ_BRANCH;
                end else begin
                    cor_req.start = 1'b1;
                    cor_req.mode  = tpgac_pkg::COR_VEC;
                    cor_y_in = CW'($signed(acc_reg[31:0])) <<< 1;
                    cor_x_in = CW'(n_reg) - (CW'(s_reg) <<< 1);
                    st_next  = tpgac_pkg::SQ_YAWW;
                end
            end
            tpgac_pkg::SQ_YAWW: begin
                if (cor_done) begin
                    yaw_next = cor_z;
                    st_next  = tpgac_pkg::SQ_BRANCH;
                end
            end
            tpgac_pkg::SQ_BRANCH: begin
                cor_req.start = 1'b1;
                if (far) begin
                    cor_req.mode = tpgac_pkg::COR_VEC;
                    cor_x_in = CW'(dx_reg);
                    cor_y_in = CW'(dy_reg);
                    st_next  = tpgac_pkg::SQ_HEADW;
                end else begin
                    cor_req.mode = tpgac_pkg::COR_ROT;
                    cor_z_in = yaw_reg;
                    st_next  = tpgac_pkg::SQ_ROTW;
                end
            end
            tpgac_pkg::SQ_HEADW: begin
                if (cor_done) begin
                    err_next = 33'(cor_z) - 33'(yaw_reg);
                    st_next  = tpgac_pkg::SQ_WRAP;
                end
            end
            tpgac_pkg::SQ_WRAP: begin
                if (err_reg > 33'(tpgac_pkg::PI_Q28)) begin
                    err_next = err_reg - 33'(tpgac_pkg::TWO_PI_Q28);
                end else if (err_reg < -33'(tpgac_pkg::PI_Q28)) begin
                    err_next = err_reg + 33'(tpgac_pkg::TWO_PI_Q28);
                end
                mop_next = tpgac_pkg::MOP_GAIN;
                st_next  = tpgac_pkg::SQ_MUL;
            end
            tpgac_pkg::SQ_ROTW: begin
                if (cor_done) begin
                    c_next   = $signed(cor_x[32:0]);
                    sn_next  = $signed(cor_y[32:0]);
                    mop_next = tpgac_pkg::MOP_EXTC;
                    st_next  = tpgac_pkg::SQ_MUL;
                end
            end
            tpgac_pkg::SQ_OUT: begin
                // hold until the output register is free
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    muser_next = rv_reg;
                    mdata_next = {6'd0, dist_reg, phase_reg, ratt_reg, rang_reg, rlin_reg};
                    st_next    = tpgac_pkg::SQ_IDLE;
                end
            end
            default: st_next = tpgac_pkg::SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= tpgac_pkg::SQ_IDLE;
            mop_reg   <= tpgac_pkg::MOP_AXX;
            phase_reg <= tpgac_pkg::PH_IDLE;
            tx_reg    <= '0;
            ty_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            st_reg    <= st_next;
            mop_reg   <= mop_next;
            phase_reg <= phase_next;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        qz_reg    <= qz_next;
        qw_reg    <= qw_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        dist_reg  <= dist_next;
        n_reg     <= n_next;
        s_reg     <= s_next;
        g_reg     <= g_next;
        yaw_reg   <= yaw_next;
        err_reg   <= err_next;
        c_reg     <= c_next;
        sn_reg    <= sn_next;
        rv_reg    <= rv_next;
        ratt_reg  <= ratt_next;
        rlin_reg  <= rlin_next;
        rang_reg  <= rang_next;
        muser_reg <= muser_next;
        mdata_reg <= mdata_next;
    end

endmodule

`default_nettype wire

// ===== rtl/tpgac_checker.sv =====
`default_nettype none

module tpgac_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tuser
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_attach_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tuser && (m_tdata[34:33] == 2'd0) &&
                                    (m_tdata[31:0] == 32'd0))
        else $error("attach without a stop command into idle");

    a_no_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[31:0] == 32'd0) && (m_tdata[65:32] == 34'd0 ||
                                  m_tdata[65:33] == 33'd0 || m_tdata[65:35] == 31'd0))
        else $error("fields set without a command");

    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34:33] != 2'd3))
        else $error("phase three reported");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind two_phase_goal_approach_controller tpgac_checker u_tpgac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== verif/two_phase_goal_approach_controller_test.sv =====
`timescale 1ns / 100ps

module two_phase_goal_approach_controller_test;

    localparam longint PI_L = 843314857;
    localparam longint HPI_L = 421657428;
    localparam longint TWO_PI_L = 1686629713;
    localparam longint GAIN_K = 652032874;
    localparam longint S32_MIN = -(64'sd1 <<< 31);
    localparam longint S32_MAX = (64'sd1 <<< 31) - 64'sd1;
    localparam int NITER = tpgac_pkg::CORDIC_ITERATIONS_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        kind;
        logic [127:0] data;
    } tick_t;

    typedef struct packed {
        logic        valid;
        logic [71:0] data;
    } cmd_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [71:0]  m_tdata;
    logic         m_tuser;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    two_phase_goal_approach_controller dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // predictor state
    longint goal_x, goal_y, target_x, target_y;
    longint tol, cruise, gain, ext;
    logic [1:0] phase;

    tick_t pending_ticks[$];
    cmd_t  expected_cmds[$];
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    mismatches = 0;
    int    idle_cycles = 0;

    longint atan_tab[24] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32};

    function automatic void add_tick(tick_t t);
        pending_ticks = {pending_ticks, t};
    endfunction

    function automatic void add_expect(cmd_t c);
        expected_cmds = {expected_cmds, c};
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint heading_of(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        while (abs64(x) < (64'sd1 <<< 40) && abs64(y) < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HPI_L;
            end else begin
                x = -y; y = t; z = -HPI_L;
            end
        end
        for (int i = 0; i < NITER; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += atan_tab[i];
            end else begin
                x -= ys; y += xs; z -= atan_tab[i];
            end
        end
        return z;
    endfunction

    function automatic void rotate_unit(longint a, output longint c, output longint s);
        longint x, y, xs, ys;
        bit neg;
        x = GAIN_K; y = 0; neg = 0;
        if (a > HPI_L) begin
            a -= PI_L; neg = 1;
        end else if (a < -HPI_L) begin
            a += PI_L; neg = 1;
        end
        for (int i = 0; i < NITER; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0) begin
                x -= ys; y += xs; a -= atan_tab[i];
            end else begin
                x += ys; y -= xs; a += atan_tab[i];
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint range_to(longint dx, longint dy);
        longint ax, ay;
        logic [63:0] v, r, b;
        ax = abs64(dx); ay = abs64(dy);
        if (ax >= (64'sd1 <<< 31) || ay >= (64'sd1 <<< 31)) return 64'h7FFFFFFF;
        v = ax * ax + ay * ay;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return r > 64'h7FFFFFFF ? 64'h7FFFFFFF : longint'(r);
    endfunction

    function automatic longint yaw_from(logic [127:0] d);
        longint qx, qy, qz, qw, n, g;
        qx = longint'($signed(d[79:64]));
        qy = longint'($signed(d[95:80]));
        qz = longint'($signed(d[111:96]));
        qw = longint'($signed(d[127:112]));
        n = qx * qx + qy * qy + qz * qz + qw * qw;
        g = 2 * (qx * qz - qw * qy);
        if (n == 0 || abs64(g) >= n) return 0;
        return heading_of(2 * (qx * qy + qw * qz), n - 2 * (qy * qy + qz * qz));
    endfunction

    function automatic cmd_t steer(tick_t t);
        cmd_t r;
        longint dx, dy, lin, ang, dist_val, err, c, s;
        logic valid, attach;
        lin = 0; ang = 0; dist_val = 0; valid = 0; attach = 0;
        if (t.kind == 1'b0) begin
            target_x = goal_x; target_y = goal_y; phase = tpgac_pkg::PH_GOAL;
            r.valid = 0;
            r.data = '0;
            r.data[34:33] = tpgac_pkg::PH_GOAL;
            return r;
        end
        dx = target_x - longint'($signed(t.data[31:0]));
        dy = target_y - longint'($signed(t.data[63:32]));
        if (phase == tpgac_pkg::PH_GOAL) begin
            dist_val = range_to(dx, dy);
            valid = 1;
            if (dist_val > tol) begin
                err = heading_of(dy, dx) - yaw_from(t.data);
                if (err > PI_L) err -= TWO_PI_L;
                else if (err < -PI_L) err += TWO_PI_L;
                lin = cruise;
                ang = clamp(rnd_shift(gain * err, 28), -32768, 32767);
            end else begin
                rotate_unit(yaw_from(t.data), c, s);
                target_x = clamp(target_x + rnd_shift(ext * c, 30), S32_MIN, S32_MAX);
                target_y = clamp(target_y + rnd_shift(ext * s, 30), S32_MIN, S32_MAX);
                phase = tpgac_pkg::PH_EXT;
            end
        end else if (phase == tpgac_pkg::PH_EXT) begin
            dist_val = range_to(dx, dy);
            valid = 1;
            if (dist_val > tol) lin = cruise;
            else begin
                attach = 1; phase = tpgac_pkg::PH_IDLE;
            end
        end else phase = tpgac_pkg::PH_IDLE;
        r.valid = valid;
        r.data = '0;
        r.data[15:0] = lin[15:0];
        r.data[31:16] = ang[15:0];
        r.data[32] = attach;
        r.data[34:33] = phase;
        r.data[65:35] = dist_val[30:0];
        return r;
    endfunction

    // handshake seen at the last rising edge
    logic s_tready_q = 0;
    always @(posedge aclk) s_tready_q <= s_tvalid && s_tready;

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_q) begin
                if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    tick_t t;
                    t = pending_ticks.pop_front();
                    add_expect(steer(t));
                    s_tvalid <= 1;
                    s_tuser <= t.kind;
                    s_tdata <= t.data;
                end else s_tvalid <= 0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transfer %h", m_tdata);
                end else begin
                    cmd_t e;
                    e = expected_cmds.pop_front();
                    if (e.valid !== m_tuser || e.data !== m_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %b %h, got %b %h",
                                     e.valid, e.data, m_tuser, m_tdata);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            tpgac_pkg::REG_GOAL_X:    goal_x = longint'($signed(val));
            tpgac_pkg::REG_GOAL_Y:    goal_y = longint'($signed(val));
            tpgac_pkg::REG_TOLERANCE: tol = val[15:0];
            tpgac_pkg::REG_CRUISE:    cruise = val[14:0];
            tpgac_pkg::REG_TURN_GAIN: gain = val[15:0];
            tpgac_pkg::REG_EXTEND:    ext = val[20:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_ticks.size() > 0 || expected_cmds.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'd0;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic tick_t make_tick(logic kind, longint px, longint py);
        tick_t t;
        t.kind = kind;
        t.data = {rand_quat(), rand_quat(), rand_quat(), rand_quat(), px[31:0], py[31:0]};
        t.data[63:0] = {py[31:0], px[31:0]};
        return t;
    endfunction

    // an approach: start, ticks closing in on goal, then ticks near the extension distance past it in x
    task automatic queue_approach(int steps);
        longint px, py, span;
        add_tick(make_tick(0, 0, 0));
        span = $urandom_range(3) == 0 ? 64'd1 << 30 : 64'd1 << 18;
        px = goal_x + $signed($urandom_range(32'(span))) - span / 2;
        py = goal_y + $signed($urandom_range(32'(span))) - span / 2;
        for (int i = 0; i < steps; i++) begin
            px = clamp(px + (goal_x - px) / 3, S32_MIN, S32_MAX);
            py = clamp(py + (goal_y - py) / 3, S32_MIN, S32_MAX);
            if (i == steps / 2) begin
                px = goal_x; py = goal_y;
            end
            if (i > steps / 2) begin
                px = clamp(goal_x + longint'(ext) - $urandom_range(2 * tol + 1),
                           S32_MIN, S32_MAX);
                py = goal_y;
            end
            if ($urandom_range(9) == 0)
                add_tick(make_tick($urandom_range(1),
                    $signed($urandom()), $signed($urandom())));
            else add_tick(make_tick(1, px, py));
        end
    endtask

    initial begin
        tick_t t;
        goal_x = 0; goal_y = 0; tol = 3277; cruise = 410; gain = 6144; ext = 19661;
        phase = tpgac_pkg::PH_IDLE; target_x = 0; target_y = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: idle ticks, extremes, degenerate quaternions
        add_tick(make_tick(1, 0, 0));
        add_tick(make_tick(0, 0, 0));
        t.kind = 1; t.data = '0;
        add_tick(t);
        add_tick(make_tick(0, 0, 0));
        t.data = {16'sd16384, 16'd0, 16'd0, 16'd0, 32'h7FFFFFFF, 32'h80000000};
        add_tick(t);
        t.data = {16'sd11585, 16'd0, -16'sd11585, 16'd0, 32'h00010000, 32'hFFFF0000};
        add_tick(t);
        t.data = {16'd0, 16'sd16384, 16'd0, 16'd0, 32'd100, 32'd100};
        add_tick(t);
        t.data = {-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 32'd0, 32'd0};
        add_tick(t);
        add_tick(make_tick(1, 0, 0));
        t.data = {16'd0, 16'd0, 16'd0, 16'sd16384, 32'd19661, 32'd0};
        add_tick(t);
        add_tick(make_tick(1, 0, 0));
        drain();

        write_reg(tpgac_pkg::REG_GOAL_X, 32'h7FFFFFFF);
        write_reg(tpgac_pkg::REG_GOAL_Y, 32'h80000000);
        write_reg(tpgac_pkg::REG_TOLERANCE, 32'h0000FFFF);
        write_reg(tpgac_pkg::REG_CRUISE, 32'h00007FFF);
        write_reg(tpgac_pkg::REG_TURN_GAIN, 32'h0000FFFF);
        write_reg(tpgac_pkg::REG_EXTEND, 32'h00100000);
        add_tick(make_tick(0, 0, 0));
        add_tick(make_tick(1, 32'h80000000, 32'h7FFFFFFF));
        add_tick(make_tick(1, 32'h7FFFFFFF, 32'h80000000));
        add_tick(make_tick(1, 32'h7FFFFFFF, 32'h80000000));
        add_tick(make_tick(1, 32'h7FFFFFFF, 32'h80000000));
        drain();

        // random approaches under three idling regimes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = ph == 0 ? 30 : (ph == 1 ? 67 : 0);
            recv_idle_pct = ph == 0 ? 67 : (ph == 1 ? 30 : 0);
            for (int k = 0; k < 4; k++) begin
                write_reg(tpgac_pkg::REG_GOAL_X, $urandom());
                write_reg(tpgac_pkg::REG_GOAL_Y, $urandom());
                write_reg(tpgac_pkg::REG_TOLERANCE, k == 0 ? 0 : $urandom_range(65535));
                write_reg(tpgac_pkg::REG_CRUISE, k == 1 ? 0 : $urandom_range(32767));
                write_reg(tpgac_pkg::REG_TURN_GAIN, k == 2 ? 0 : $urandom());
                write_reg(tpgac_pkg::REG_EXTEND, k == 3 ? 0 : $urandom_range(1048576));
                for (int a = 0; a < 16; a++) queue_approach($urandom_range(4, 14));
                drain();
            end
        end

        if (mismatches == 0 && expected_cmds.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
